### hdl/adaptive_multisymbol_range_decoder_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the range decoder
// Checks compile to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ADAPTIVE_MULTISYMBOL_RANGE_DECODER_ASSERT_SVH
`define ADAPTIVE_MULTISYMBOL_RANGE_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define AMRD_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define AMRD_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define AMRD_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define AMRD_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

### hdl/amrd_pkg.sv
// ---------------------------------------------------------------------------
// amrd_pkg
// Shared types and constants of the range decoder.
// ---------------------------------------------------------------------------
package amrd_pkg;
    localparam int CONTEXTS     = 256;
    localparam int MAX_ALPHABET = 16;
    localparam int ROW_WORDS    = MAX_ALPHABET + 1;
    localparam int CTX_W        = $clog2(CONTEXTS);
    localparam int WORD_W       = 5;
    localparam int ADDR_W       = $clog2(CONTEXTS * 32);

    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_LOAD = 2'd1,
        OP_SYM  = 2'd2,
        OP_BOOL = 2'd3
    } t_op;

    // Memory request from the sequencer to the table.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [15:0]       wdata;
    } t_mem_req;

    function automatic logic [ADDR_W-1:0] word_addr(input logic [CTX_W-1:0] ctx,
                                                   input logic [WORD_W-1:0] w);
        return {ctx, w};
    endfunction
endpackage

### hdl/amrd_cdf_ram.sv
// ---------------------------------------------------------------------------
// amrd_cdf_ram
// Single-port CDF table, registered read.
// ---------------------------------------------------------------------------
module amrd_cdf_ram (
    input  logic                 i_clk,
    input  amrd_pkg::t_mem_req   i_req,
    output logic [15:0]          o_rdata
);
    logic [15:0] r_mem [0:(1 << amrd_pkg::ADDR_W)-1];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end
endmodule

### hdl/adaptive_multisymbol_range_decoder.sv
// ---------------------------------------------------------------------------
// adaptive_multisymbol_range_decoder
// Init and load go straight to the result; bool and symbol decodes step word
// by word through the single table port and the one shared multiplier, and
// adaptation adds a read-modify-write pass over the row's words. busy holds
// for the whole request; the next request can be taken in the cycle the
// result strobes. The receiver cannot stall.
// Synchronous active-low reset; the CDF table is not cleared.
// ---------------------------------------------------------------------------
`include "adaptive_multisymbol_range_decoder_assert.svh"
module adaptive_multisymbol_range_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_context_index,
    input  logic [4:0]  i_alphabet_size,
    input  logic [4:0]  i_entry_index,
    input  logic [15:0] i_entry_value,
    input  logic [14:0] i_stream_window,
    input  logic [20:0] i_tile_bytes,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output logic        o_valid,
    output logic [3:0]  o_symbol,
    output logic [3:0]  o_bits_consumed
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RD    = 10'b0000000010,
        S_CMP   = 10'b0000000100,
        S_MUL   = 10'b0000001000,
        S_NORM  = 10'b0000010000,
        S_CNTRD = 10'b0000100000,
        S_CNT   = 10'b0001000000,
        S_ARD   = 10'b0010000000,
        S_AWR   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic        r_adapt;
    logic [15:0] r_val, r_rng, r_prev, r_cur;
    logic signed [24:0] r_bud;
    logic [7:0]  r_ctx;
    logic [4:0]  r_n, r_i, r_sym;
    logic [14:0] r_win;
    logic        r_bool, r_wait;
    logic [2:0]  r_rate;
    logic [3:0]  r_osym, r_obits;
    logic        r_ovalid;
    logic [31:0] r_prod;

    amrd_pkg::t_mem_req s_req;
    logic [15:0] s_rdata;

    amrd_cdf_ram u_ram (.i_clk(i_clk), .i_req(s_req), .o_rdata(s_rdata));

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_symbol    = r_osym;
    assign o_bits_consumed = r_obits;

    logic [4:0]  s_nclamp;
    logic [15:0] s_p, s_f;
    logic [16:0] s_cur_full;
    logic        s_hit;
    logic [15:0] s_rngd, s_vald;
    logic [3:0]  s_lg;
    logic [4:0]  s_bits;
    logic [4:0]  s_nb;
    logic [15:0] s_fresh;
    logic [16:0] s_newval;
    logic [15:0] s_adapt_c;
    logic [4:0]  s_rowsel;
    logic signed [25:0] s_nbud;
    logic [24:0] s_total;
    logic [3:0]  s_inb;

    always_comb begin
        s_nclamp = (i_alphabet_size < 5'd2) ? 5'd2 :
                   (i_alphabet_size > 5'(amrd_pkg::MAX_ALPHABET)) ?
                   5'(amrd_pkg::MAX_ALPHABET) : i_alphabet_size;
        s_p = r_bool ? 16'd16384 : ((s_rdata > 16'd32768) ? 16'd32768 : s_rdata);
        s_f = 16'd32768 - s_p;
        // multiplier product registered in S_MUL stage
        s_cur_full = 17'(r_prod[31:1]) + 17'({r_n - r_i - 5'd1, 2'b00});
        s_hit = (r_i + 5'd1 >= r_n) || (r_val >= s_cur_full[15:0]);
        s_rngd = r_prev - r_cur;
        if (s_rngd == 16'd0) s_rngd = 16'd1;
        s_vald = r_val - r_cur;
        s_lg = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (s_rngd[k]) s_lg = 4'(k);
        end
        s_bits = 5'd15 - {1'b0, s_lg};
        s_nb = (r_bud <= 0) ? 5'd0 :
               (r_bud < 25'(s_bits)) ? r_bud[4:0] : s_bits;
        s_fresh = (s_nb == 5'd0) ? 16'd0 :
                  16'((({1'b0, r_win} >> (5'd15 - s_nb))) << (s_bits - s_nb));
        s_newval = ((17'(s_vald) + 17'd1) << s_bits) - 17'd1;
        s_nbud = 26'(r_bud) - 26'(s_bits);
        if (s_nbud < -26'sd16777216) s_nbud = -26'sd16777216;
        // adaptation of word r_i; words below the symbol decay toward zero, the rest move toward 32768
        if (r_i < r_sym) begin
            s_adapt_c = s_rdata - (s_rdata >> r_rate);
        end else if (s_rdata > 16'd32768) begin
            s_adapt_c = s_rdata - ((s_rdata - 16'd32768) >> r_rate);
        end else begin
            s_adapt_c = s_rdata + ((16'd32768 - s_rdata) >> r_rate);
        end
        s_total = {1'b0, i_tile_bytes, 3'b000};
        s_inb = (s_total < 25'd15) ? s_total[3:0] : 4'd15;
        s_rowsel = r_i;
        if (r_state == S_IDLE) begin
            s_rowsel = (i_operation == amrd_pkg::OP_LOAD) ? i_entry_index : 5'd0;
        end else if (r_state == S_CMP) begin
            // fetch the next word while comparing
            s_rowsel = r_i + 5'd1;
        end else if (r_state == S_NORM || r_state == S_CNTRD) begin
            s_rowsel = r_n;
        end
    end

    always_comb begin
        s_req.we = 1'b0;
        s_req.addr = amrd_pkg::word_addr(
            (r_state == S_IDLE) ? i_context_index : r_ctx, s_rowsel);
        s_req.wdata = i_entry_value;
        if (r_state == S_IDLE && start && i_operation == amrd_pkg::OP_LOAD &&
            i_entry_index <= 5'(amrd_pkg::MAX_ALPHABET)) begin
            s_req.we = 1'b1;
        end else if (r_state == S_AWR) begin
            s_req.we = 1'b1;
            s_req.wdata = s_adapt_c;
        end else if (r_state == S_CNT) begin
            s_req.we = (s_rdata < 16'd32);
            s_req.wdata = s_rdata + 16'd1;
            s_req.addr = amrd_pkg::word_addr(r_ctx, r_n);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (start) begin
                         unique case (amrd_pkg::t_op'(i_operation))
                             amrd_pkg::OP_INIT, amrd_pkg::OP_LOAD: n_state = S_DONE;
                             amrd_pkg::OP_SYM:  n_state = S_RD;
                             default:           n_state = S_MUL;
                         endcase
                     end
            S_RD:    n_state = S_MUL;
            S_MUL:   n_state = S_CMP;
            S_CMP:   n_state = s_hit ? S_NORM : S_MUL;
            S_NORM:  n_state = (!r_bool && r_adapt) ? S_CNTRD : S_DONE;
            S_CNTRD: n_state = S_CNT;
            S_CNT:   n_state = S_ARD;
            S_ARD:   n_state = r_wait ? S_AWR : S_ARD;
            S_AWR:   n_state = (r_i + 5'd2 >= r_n) ? S_DONE : S_ARD;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_adapt  <= 1'b1;
            r_val    <= '0;
            r_rng    <= 16'd32768;
            r_bud    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= (r_state == S_DONE);
            if (i_cfg_valid && o_cfg_ready) r_adapt <= i_cfg_data;
            unique case (r_state)
                S_IDLE: if (start) begin
                    r_ctx <= i_context_index;
                    r_n   <= (i_operation == amrd_pkg::OP_BOOL) ? 5'd2 : s_nclamp;
                    r_win <= i_stream_window;
                    r_bool <= (i_operation == amrd_pkg::OP_BOOL);
                    r_i <= 5'd0;
                    r_prev <= r_rng;
                    r_cur <= r_rng;
                    r_osym <= 4'd0;
                    r_obits <= (i_operation == amrd_pkg::OP_INIT) ? s_inb : 4'd0;
                    if (i_operation == amrd_pkg::OP_INIT) begin
                        r_val <= 16'h7FFF ^ 16'((i_stream_window >> (4'd15 - s_inb))
                                                << (4'd15 - s_inb));
                        r_rng <= 16'd32768;
                        r_bud <= 25'(s_total) - 25'sd15;
                    end
                end
                S_RD: ;
                S_MUL: begin
                    // shared multiplier: range top byte times probability
                    if (r_i + 5'd1 >= r_n) begin
                        r_prod <= '0;
                    end else begin
                        r_prod <= 32'(r_rng[15:8]) * 32'(s_f[15:6]);
                    end
                end
                S_CMP: begin
                    r_prev <= r_cur;
                    if (r_i + 5'd1 >= r_n) begin
                        r_cur <= 16'd0;
                        r_sym <= r_i;
                    end else begin
                        r_cur <= s_cur_full[15:0];
                        if (r_val >= s_cur_full[15:0]) begin
                            r_sym <= r_i;
                        end else begin
                            r_i <= r_i + 5'd1;
                        end
                    end
                end
                S_NORM: begin
                    r_rng <= 16'(s_rngd << s_bits);
                    r_val <= s_fresh ^ s_newval[15:0];
                    r_bud <= s_nbud[24:0];
                    r_osym <= r_sym[3:0];
                    r_obits <= s_nb[3:0];
                    r_i <= 5'd0;
                    r_wait <= 1'b0;
                end
                S_CNTRD: ;
                S_CNT: begin
                    r_rate <= 3'd3 + ((s_rdata > 16'd15) ? 3'd1 : 3'd0) +
                              ((s_rdata > 16'd31) ? 3'd1 : 3'd0) +
                              ((r_n >= 5'd4) ? 3'd2 : 3'd1);
                    r_wait <= 1'b0;
                end
                S_ARD: r_wait <= 1'b1;
                S_AWR: begin
                    r_wait <= 1'b0;
                    r_i <= r_i + 5'd1;
                end
                S_DONE: ;
                default: ;
            endcase
        end
    end

    `AMRD_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "start not taken")
    `AMRD_ASSERT_IMPL(a_cfg_idle, i_clk, i_rst_n, o_cfg_ready |-> !busy, "cfg while busy")
    `AMRD_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE, o_valid, "no result")
endmodule
